[rtl/rsrp_pkg.sv]
package rsrp_pkg;

    // default sizing
    localparam int RSRP_BUFFER_BYTES = 1024;
    localparam int RSRP_MAX_REPEAT   = 251;

    // fixed field widths
    localparam int OP_W      = 2;
    localparam int MODE_W    = 2;
    localparam int VAL_W     = 15;
    localparam int THR_W     = 11;
    localparam int STORED_W  = 10;
    localparam int REP_W     = 8;
    localparam int ENTRY_W   = 24;
    localparam int REG_IDX_W = 2;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 32;

    // operation codes
    localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
    localparam logic [OP_W-1:0] OP_REWIND = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    // mode codes
    localparam logic [MODE_W-1:0] MODE_IDLE   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PLAY   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RECORD = 2'd2;

    // configuration register indexes
    localparam logic [REG_IDX_W-1:0] REG_MODE     = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_LOW_THR  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_CRIT_THR = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_TOUT_THR = 2'd3;

    // configuration reset values
    localparam logic [MODE_W-1:0] MODE_RESET     = MODE_IDLE;
    localparam logic [THR_W-1:0]  LOW_THR_RESET  = 11'd64;
    localparam logic [THR_W-1:0]  CRIT_THR_RESET = 11'd32;
    localparam logic [THR_W-1:0]  TOUT_THR_RESET = 11'd8;

    // controller to datapath commands
    typedef struct packed {
        logic load;   // capture the item and read the entry store
        logic exec;   // update state, write back, load the result register
    } rsrp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic out_free;   // result register can take a new result this cycle
    } rsrp_status_t;

endpackage

[rtl/rsrp_ctrl.sv]
module rsrp_ctrl
    import rsrp_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  rsrp_status_t status,
    output rsrp_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } ctrl_state_t;

    ctrl_state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (status.out_free) begin
                    cmd.exec   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    // no item is taken in the cycle after another item was taken
    a_exec_after_load: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> !cmd.load)
        else $error("rsrp_ctrl: accepted two items back to back");

    // execution never happens without room in the result register
    a_exec_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec |-> status.out_free)
        else $error("rsrp_ctrl: executed with result register full");

    // load and exec are exclusive
    a_cmd_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.load, cmd.exec}))
        else $error("rsrp_ctrl: load and exec in the same cycle");
`endif

endmodule

[rtl/rsrp_datapath.sv]
module rsrp_datapath
    import rsrp_pkg::*;
#(
    parameter int BUFFER_BYTES = RSRP_BUFFER_BYTES,
    parameter int MAX_REPEAT   = RSRP_MAX_REPEAT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // item payload
    input  logic [OP_W-1:0]      op_in,
    input  logic [VAL_W-1:0]     sample_in,
    // configuration writes
    input  logic                 cfg_we,
    input  logic [REG_IDX_W-1:0] cfg_idx,
    input  logic [THR_W-1:0]     cfg_wdata,
    // control
    input  rsrp_cmd_t            cmd,
    output rsrp_status_t         status,
    // result
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int DEPTH  = BUFFER_BYTES / 2;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int UB_W   = $clog2(BUFFER_BYTES + 1);
    localparam int CMP_W  = (UB_W > THR_W) ? UB_W : THR_W;

    // configuration registers
    logic [MODE_W-1:0] mode_reg;
    logic [THR_W-1:0]  low_thr_reg, crit_thr_reg, tout_thr_reg;

    // recorder state
    logic [UB_W-1:0]   used_bytes_reg, used_bytes_next;
    logic [ADDR_W-1:0] current_entry_reg, current_entry_next;
    logic              current_valid_reg, current_valid_next;
    logic [CNT_W-1:0]  entry_total_reg, entry_total_next;
    logic [CNT_W-1:0]  play_position_reg, play_position_next;
    logic [REP_W-1:0]  repeats_left_reg, repeats_left_next;
    logic              timeout_flag_reg, timeout_flag_next;

    // captured item
    logic [OP_W-1:0]   op_reg;
    logic [VAL_W-1:0]  sample_reg;

    // entry store
    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] mem_rd_data_reg;
    logic [ADDR_W-1:0]  mem_rd_addr;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_wr_addr;
    logic [ENTRY_W-1:0] mem_wr_data;

    // result register
    logic                 m_valid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    // step helpers
    logic [UB_W-1:0]   free_bytes;
    logic [UB_W-1:0]   free_after;
    logic [VAL_W-1:0]  rd_val;
    logic              rd_flag;
    logic [REP_W-1:0]  rd_reps;
    logic              pos_wrap;
    logic [ADDR_W-1:0] play_addr;
    logic [VAL_W-1:0]  drive;
    logic              low_flag, crit_flag;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_RESET;
            low_thr_reg  <= LOW_THR_RESET;
            crit_thr_reg <= CRIT_THR_RESET;
            tout_thr_reg <= TOUT_THR_RESET;
        end else if (cfg_we) begin
            case (cfg_idx)
                REG_MODE:     mode_reg     <= cfg_wdata[MODE_W-1:0];
                REG_LOW_THR:  low_thr_reg  <= cfg_wdata;
                REG_CRIT_THR: crit_thr_reg <= cfg_wdata;
                REG_TOUT_THR: tout_thr_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // play read address: hold the current entry while repeats remain
    assign pos_wrap  = (play_position_reg >= entry_total_reg);
    assign play_addr = (repeats_left_reg != '0) ? current_entry_reg :
                       (pos_wrap ? '0 : play_position_reg[ADDR_W-1:0]);
    assign mem_rd_addr = (mode_reg == MODE_PLAY) ? play_addr : current_entry_reg;

    // item capture
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg     <= op_in;
            sample_reg <= sample_in;
        end
    end

    // entry store read and write ports
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mem_rd_data_reg <= mem[mem_rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wr_addr] <= mem_wr_data;
        end
    end

    // fields of the entry that was read
    assign rd_val     = mem_rd_data_reg[VAL_W-1:0];
    assign rd_flag    = mem_rd_data_reg[VAL_W];
    assign rd_reps    = rd_flag ? mem_rd_data_reg[ENTRY_W-1:VAL_W+1] : '0;
    assign free_bytes = UB_W'(BUFFER_BYTES) - used_bytes_reg;

    // step logic
    always_comb begin
        used_bytes_next    = used_bytes_reg;
        current_entry_next = current_entry_reg;
        current_valid_next = current_valid_reg;
        entry_total_next   = entry_total_reg;
        play_position_next = play_position_reg;
        repeats_left_next  = repeats_left_reg;
        timeout_flag_next  = timeout_flag_reg;
        mem_we             = 1'b0;
        mem_wr_addr        = current_entry_reg;
        mem_wr_data        = mem_rd_data_reg;
        drive              = '0;
        case (op_reg)
            OP_TICK: begin
                case (mode_reg)
                    MODE_PLAY: begin
                        current_valid_next = 1'b0;
                        if (entry_total_reg != '0) begin
                            drive = rd_val;
                            if (repeats_left_reg != '0) begin
                                repeats_left_next = repeats_left_reg - 1'b1;
                            end else begin
                                current_entry_next = play_addr;
                                repeats_left_next  = rd_reps;
                                play_position_next = CNT_W'(play_addr) + 1'b1;
                            end
                        end
                    end
                    MODE_RECORD: begin
                        drive = sample_reg;
                        if (CMP_W'(free_bytes) < CMP_W'(tout_thr_reg)) begin
                            timeout_flag_next = 1'b1;
                        end else if (!current_valid_reg || rd_val != sample_reg ||
                                     rd_reps >= REP_W'(MAX_REPEAT)) begin
                            // start a new single entry
                            if (free_bytes < UB_W'(2) ||
                                entry_total_reg >= CNT_W'(DEPTH)) begin
                                timeout_flag_next = 1'b1;
                            end else begin
                                mem_we             = 1'b1;
                                mem_wr_addr        = entry_total_reg[ADDR_W-1:0];
                                mem_wr_data        = ENTRY_W'(sample_reg);
                                current_entry_next = entry_total_reg[ADDR_W-1:0];
                                entry_total_next   = entry_total_reg + 1'b1;
                                used_bytes_next    = used_bytes_reg + UB_W'(2);
                                current_valid_next = 1'b1;
                            end
                        end else if (!rd_flag) begin
                            // single entry becomes a repeated entry
                            if (free_bytes == '0) begin
                                timeout_flag_next = 1'b1;
                            end else begin
                                mem_we          = 1'b1;
                                mem_wr_data     = {REP_W'(1), 1'b1, rd_val};
                                used_bytes_next = used_bytes_reg + UB_W'(1);
                            end
                        end else begin
                            // bump the repeat count
                            mem_we      = 1'b1;
                            mem_wr_data = {rd_reps + 1'b1, 1'b1, rd_val};
                        end
                    end
                    default: ;
                endcase
            end
            OP_REWIND: begin
                play_position_next = '0;
                repeats_left_next  = '0;
                current_valid_next = 1'b0;
                timeout_flag_next  = 1'b0;
            end
            OP_CLEAR: begin
                used_bytes_next    = '0;
                current_entry_next = '0;
                current_valid_next = 1'b0;
                entry_total_next   = '0;
                play_position_next = '0;
                repeats_left_next  = '0;
                timeout_flag_next  = 1'b0;
            end
            default: ;
        endcase
        if (!cmd.exec) begin
            mem_we = 1'b0;
        end
    end

    // buffer level flags after the step
    assign free_after = UB_W'(BUFFER_BYTES) - used_bytes_next;
    assign low_flag   = (CMP_W'(free_after) < CMP_W'(low_thr_reg));
    assign crit_flag  = (CMP_W'(free_after) < CMP_W'(crit_thr_reg));

    // recorder state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_bytes_reg    <= '0;
            current_entry_reg <= '0;
            current_valid_reg <= 1'b0;
            entry_total_reg   <= '0;
            play_position_reg <= '0;
            repeats_left_reg  <= '0;
            timeout_flag_reg  <= 1'b0;
        end else if (cmd.exec) begin
            used_bytes_reg    <= used_bytes_next;
            current_entry_reg <= current_entry_next;
            current_valid_reg <= current_valid_next;
            entry_total_reg   <= entry_total_next;
            play_position_reg <= play_position_next;
            repeats_left_reg  <= repeats_left_next;
            timeout_flag_reg  <= timeout_flag_next;
        end
    end

    // result register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.exec) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            m_tdata_reg <= M_TDATA_W'({STORED_W'(entry_total_next), crit_flag, low_flag,
                                       timeout_flag_next, drive});
        end
    end

    assign m_tvalid        = m_valid_reg;
    assign m_tdata         = m_tdata_reg;
    assign status.out_free = !m_valid_reg || m_tready;

`ifndef NO_ASSERTIONS
    // budget is never overrun
    a_used_in_budget: assert property (@(posedge aclk) disable iff (!aresetn)
        used_bytes_reg <= UB_W'(BUFFER_BYTES))
        else $error("rsrp_datapath: used bytes beyond buffer size");

    // entry count stays within the store
    a_total_in_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        entry_total_reg <= CNT_W'(DEPTH))
        else $error("rsrp_datapath: entry count beyond store depth");

    // play pointer never passes the entry count
    a_pos_in_total: assert property (@(posedge aclk) disable iff (!aresetn)
        play_position_reg <= entry_total_reg)
        else $error("rsrp_datapath: play position beyond entry count");

    // a current entry always refers to a written entry
    a_current_written: assert property (@(posedge aclk) disable iff (!aresetn)
        current_valid_reg |-> (CNT_W'(current_entry_reg) < entry_total_reg))
        else $error("rsrp_datapath: current entry not written");

    // each new entry costs exactly two bytes
    a_append_cost: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.exec && entry_total_next == entry_total_reg + 1'b1) |=>
        used_bytes_reg == $past(used_bytes_reg) + UB_W'(2))
        else $error("rsrp_datapath: append did not charge two bytes");
`endif

endmodule

[rtl/rle_sample_record_playback.sv]
// channel   direction  handshake                 payload
// s_        in         s_tvalid / s_tready       s_tuser operation, s_tdata sample_value
// m_        out        m_tvalid / m_tready       m_tdata drive_value and status
// cfg_      in         cfg_valid / cfg_ready     cfg_index register, cfg_data value
//
// each item is handled in a load step, which captures it and reads the entry store,
// then an execute step, which updates state, writes the entry back and loads the result register.
// the registered read of the entry store ahead of the write-back makes these separate steps.
// an item waits in its execute step while the result register is full; no new item is taken meanwhile.
// reset is synchronous on aresetn low; the entry store needs no clearing pass.
// configuration writes are taken in every cycle.
module rle_sample_record_playback
    import rsrp_pkg::*;
#(
    parameter int BUFFER_BYTES = RSRP_BUFFER_BYTES,
    parameter int MAX_REPEAT   = RSRP_MAX_REPEAT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // input items
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [14:0] sample_value, [15] zero
    input  logic [OP_W-1:0]      s_tuser,   // [1:0] operation
    // result items
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [14:0] drive_value, [15] timed_out,
                                            // [16] buffer_low, [17] buffer_critical,
                                            // [27:18] stored_entries, [31:28] zero
    // configuration writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [THR_W-1:0]     cfg_data
);

    rsrp_cmd_t    cmd;
    rsrp_status_t status;

    assign cfg_ready = 1'b1;

    rsrp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    rsrp_datapath #(
        .BUFFER_BYTES (BUFFER_BYTES),
        .MAX_REPEAT   (MAX_REPEAT)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .op_in     (s_tuser),
        .sample_in (s_tdata[VAL_W-1:0]),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_idx   (cfg_index),
        .cfg_wdata (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
